// ===== rtl/kli_pkg.sv =====
// Shared constants for the knot table linear interpolator: widths, word layouts, codes.
package kli_pkg;

	// Fixed-point format of every value field
	localparam int DATA_W    = 32;
	localparam int FRAC_BITS = 16;

	// 1.0 in the value format, one bit wider so it compares against signed sums
	localparam logic signed [DATA_W:0] ONE_EXT =
		{{(DATA_W - FRAC_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [DATA_W-1:0] ONE = ONE_EXT[DATA_W-1:0];

	// Field widths fixed by the word format
	localparam int IDX_W   = 4;
	localparam int COUNT_W = 5;

	// Input word layout (tdata), lowest bit first
	localparam int TD_IDX_LSB  = 0;
	localparam int TD_X_LSB    = TD_IDX_LSB + IDX_W;
	localparam int TD_Y_LSB    = TD_X_LSB + DATA_W;
	localparam int TD_S_LSB    = TD_Y_LSB + DATA_W;
	localparam int IN_TDATA_W  = ((TD_S_LSB + DATA_W + 7) / 8) * 8;
	localparam int IN_TUSER_W  = 2;
	localparam int IN_USER_CMD = 0;
	localparam int IN_USER_NAN = 1;

	// Output word layout
	localparam int OUT_TDATA_W   = DATA_W;
	localparam int OUT_TUSER_W   = 2;
	localparam int OUT_USER_NAN  = 0;
	localparam int OUT_USER_CLMP = 1;

	// Commands
	localparam logic CMD_LOAD    = 1'b0;
	localparam logic CMD_CONVERT = 1'b1;

	// Serial divider: one quotient bit per cycle
	localparam int DIV_STEPS = DATA_W;
	localparam int DIV_CW    = $clog2(DIV_STEPS);

endpackage

// ===== rtl/kli_div.sv =====
// Bit-serial restoring divider: 64-bit dividend by 32-bit divisor, 32-bit quotient.
module kli_div
	import kli_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [2*DATA_W-1:0]   dividend,
	input  logic [DATA_W-1:0]     divisor,
	output logic [DATA_W-1:0]     quotient,
	output logic                  done
);

	logic                busy_q;
	logic                done_q;
	logic [DIV_CW-1:0]   cnt_q;
	logic [DATA_W-1:0]   rem_q;
	logic [DATA_W-1:0]   low_q;
	logic [DATA_W-1:0]   dsr_q;
	logic [DATA_W-1:0]   quo_q;
	logic [DATA_W:0]     partial;
	logic [DATA_W+1:0]   trial;
	logic                ge;
	logic [DATA_W-1:0]   rem_next;

	// One trial subtract per cycle; remainder stays below the divisor
	// because the quotient is known to fit in DATA_W bits
	assign partial  = {rem_q, low_q[DATA_W-1]};
	assign trial    = {1'b0, partial} - {2'b00, dsr_q};
	assign ge       = ~trial[DATA_W+1];
	assign rem_next = ge ? trial[DATA_W-1:0] : partial[DATA_W-1:0];

	// Step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CW'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[2*DATA_W-1:DATA_W];
			low_q <= dividend[DATA_W-1:0];
			dsr_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_next;
			low_q <= {low_q[DATA_W-2:0], 1'b0};
			quo_q <= {quo_q[DATA_W-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// ===== rtl/knot_table_linear_interpolator_top.sv =====
// Top level of the knot table linear interpolator: knot store, scan sequencer, output register.
//
//  channel   direction  words                          handshake
//  s_axis    in         load knot / convert sample     tvalid, tready
//  m_axis    out        interpolated value + flags     tvalid, tready
//  cfg       in         knot_count (5 bits)            valid, ready
//
// A load word writes one knot to the store. A convert word scans up to knot k,
// k being the index of the first knot at or above the sample: the scan reads the knot
// store through its single read port one knot a cycle, then a serial divider gives
// one quotient bit a cycle. Boundary results skip the divider; NaN skips the scan too.
// Reset clears the sequencer and sets knot_count to 2; the knot store is not cleared.
// A result stalled at m_axis holds the sequencer in its last step.
module knot_table_linear_interpolator_top
	import kli_pkg::*;
#(
	parameter int MAX_KNOTS = 16
)
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	// knot_index, knot_x, knot_y, sample, zero padding
	input  logic [IN_TDATA_W-1:0]   s_axis_tdata,
	// command, sample_is_nan
	input  logic [IN_TUSER_W-1:0]   s_axis_tuser,
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	// scaled_value
	output logic [OUT_TDATA_W-1:0]  m_axis_tdata,
	// result_is_nan, was_clamped
	output logic [OUT_TUSER_W-1:0]  m_axis_tuser,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [COUNT_W-1:0]      cfg_data
);

	localparam int AW = $clog2(MAX_KNOTS);
	localparam int CW = AW + 1;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_MUL    = 3'd2;
	localparam logic [2:0] ST_DSTART = 3'd3;
	localparam logic [2:0] ST_DWAIT  = 3'd4;
	localparam logic [2:0] ST_OUT    = 3'd5;

	logic [2:0]                 state_q;
	logic [COUNT_W-1:0]         knot_count_q;
	logic [CW-1:0]              cnt_q;
	logic                       m_valid_q;
	logic [OUT_TDATA_W-1:0]     m_data_q;
	logic [OUT_TUSER_W-1:0]     m_user_q;

	logic [2*DATA_W-1:0]        mem [MAX_KNOTS];
	logic [2*DATA_W-1:0]        rd_q;
	logic [AW-1:0]              rd_addr;
	logic [AW-1:0]              wr_addr;
	logic                       wr_en;

	logic                       in_acc;
	logic                       in_cmd;
	logic                       in_nan;
	logic [IDX_W-1:0]           in_idx;
	logic [31:0]                idx_ext;
	logic [DATA_W-1:0]          in_x;
	logic [DATA_W-1:0]          in_y;
	logic signed [DATA_W-1:0]   in_sample;

	logic [31:0]                kc_ext;
	logic [31:0]                n_eff;
	logic [CW-1:0]              n_last;
	logic [CW-1:0]              k;
	logic                       have;
	logic                       hit;
	logic                       at_last;

	logic signed [DATA_W-1:0]   sample_q;
	logic signed [DATA_W-1:0]   prev_x_q;
	logic signed [DATA_W-1:0]   prev_y_q;
	logic signed [DATA_W-1:0]   cur_x;
	logic signed [DATA_W-1:0]   cur_y;
	logic signed [DATA_W:0]     u_full;
	logic signed [DATA_W:0]     dx_full;
	logic signed [DATA_W:0]     dy_full;
	logic signed [DATA_W:0]     mag_full;
	logic [DATA_W-1:0]          u_q;
	logic [DATA_W-1:0]          dx_q;
	logic [DATA_W-1:0]          mag_q;
	logic                       neg_q;
	logic [2*DATA_W-1:0]        prod_q;
	logic signed [DATA_W:0]     res_q;
	logic signed [DATA_W:0]     res_calc;
	logic                       nan_q;
	logic                       over;
	logic                       slot_free;

	logic                       div_start;
	logic                       div_done;
	logic [DATA_W-1:0]          quotient;

	// Input word unpacking
	assign in_acc    = s_axis_tvalid & s_axis_tready;
	assign in_cmd    = s_axis_tuser[IN_USER_CMD];
	assign in_nan    = s_axis_tuser[IN_USER_NAN];
	assign in_idx    = s_axis_tdata[TD_IDX_LSB +: IDX_W];
	assign in_x      = s_axis_tdata[TD_X_LSB +: DATA_W];
	assign in_y      = s_axis_tdata[TD_Y_LSB +: DATA_W];
	assign in_sample = s_axis_tdata[TD_S_LSB +: DATA_W];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;

	// Knot store write: indexes past the table are dropped
	assign idx_ext = 32'(in_idx);
	assign wr_addr = idx_ext[AW-1:0];
	assign wr_en   = in_acc && (in_cmd == CMD_LOAD) && (idx_ext < 32'(MAX_KNOTS));
	assign rd_addr = cnt_q[AW-1:0];

	// Knot store: y in the upper half, x in the lower, registered read
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= {in_y, in_x};
		rd_q <= mem[rd_addr];
	end

	assign cur_x = rd_q[DATA_W-1:0];
	assign cur_y = rd_q[2*DATA_W-1:DATA_W];

	// Knots in use, held to the range 2..MAX_KNOTS
	assign kc_ext = 32'(knot_count_q);
	assign n_eff  = (kc_ext < 32'd2) ? 32'd2 :
	                (kc_ext > 32'(MAX_KNOTS)) ? 32'(MAX_KNOTS) : kc_ext;
	assign n_last = CW'(n_eff - 32'd1);

	// Scan: read data lags the address by the read register
	assign have    = (cnt_q != '0);
	assign k       = cnt_q - 1'b1;
	assign hit     = (cur_x >= sample_q);
	assign at_last = (k == n_last);

	// Segment differences against the previous knot
	assign u_full   = {sample_q[DATA_W-1], sample_q} - {prev_x_q[DATA_W-1], prev_x_q};
	assign dx_full  = {cur_x[DATA_W-1], cur_x} - {prev_x_q[DATA_W-1], prev_x_q};
	assign dy_full  = {cur_y[DATA_W-1], cur_y} - {prev_y_q[DATA_W-1], prev_y_q};
	assign mag_full = dy_full[DATA_W] ? -dy_full : dy_full;

	// y0 moved by the quotient towards y1
	assign res_calc = neg_q ? ({prev_y_q[DATA_W-1], prev_y_q} - {1'b0, quotient})
	                        : ({prev_y_q[DATA_W-1], prev_y_q} + {1'b0, quotient});

	assign over      = !nan_q && (res_q > ONE_EXT);
	assign slot_free = !m_valid_q || m_axis_tready;
	assign div_start = (state_q == ST_DSTART);

	// Sequencer and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			knot_count_q <= COUNT_W'(2);
			m_valid_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				knot_count_q <= cfg_data;
			// Result word posted from the last step, held until taken
			m_valid_q <= ((state_q == ST_OUT) && slot_free) || (m_valid_q && !m_axis_tready);
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_acc && (in_cmd == CMD_CONVERT))
						state_q <= in_nan ? ST_OUT : ST_SCAN;
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (have) begin
						if (hit)
							state_q <= (k == '0) ? ST_OUT : ST_MUL;
						else if (at_last)
							state_q <= ST_OUT;
					end
				end
				ST_MUL:    state_q <= ST_DSTART;
				ST_DSTART: state_q <= ST_DWAIT;
				ST_DWAIT: begin
					if (div_done)
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (slot_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc && (in_cmd == CMD_CONVERT)) begin
					sample_q <= in_sample;
					nan_q    <= in_nan;
					res_q    <= '0;
				end
			end
			ST_SCAN: begin
				if (have) begin
					if (hit && (k != '0)) begin
						u_q   <= u_full[DATA_W-1:0];
						dx_q  <= dx_full[DATA_W-1:0];
						mag_q <= mag_full[DATA_W-1:0];
						neg_q <= dy_full[DATA_W];
					end else if (hit || at_last) begin
						res_q <= {cur_y[DATA_W-1], cur_y};
					end else begin
						prev_x_q <= cur_x;
						prev_y_q <= cur_y;
					end
				end
			end
			ST_MUL: prod_q <= u_q * mag_q;
			ST_DWAIT: begin
				if (div_done)
					res_q <= res_calc;
			end
			ST_OUT: begin
				if (slot_free) begin
					m_data_q                <= over ? ONE : res_q[DATA_W-1:0];
					m_user_q[OUT_USER_NAN]  <= nan_q;
					m_user_q[OUT_USER_CLMP] <= over;
				end
			end
			default: ;
		endcase
	end

	kli_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (dx_q),
		.quotient (quotient),
		.done     (div_done)
	);

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

endmodule

// ===== rtl/kli_chk.sv =====
// Port-level checker for the knot table linear interpolator, bound to the top level.
module kli_chk
	import kli_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    s_axis_tvalid,
	input logic                    s_axis_tready,
	input logic [IN_TDATA_W-1:0]   s_axis_tdata,
	input logic [IN_TUSER_W-1:0]   s_axis_tuser,
	input logic                    m_axis_tvalid,
	input logic                    m_axis_tready,
	input logic [OUT_TDATA_W-1:0]  m_axis_tdata,
	input logic [OUT_TUSER_W-1:0]  m_axis_tuser,
	input logic                    cfg_valid,
	input logic                    cfg_ready,
	input logic [COUNT_W-1:0]      cfg_data
);

	// A stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result word changed while stalled");

	// A convert word keeps the input closed for at least the next cycle
	a_busy_after_convert: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser[IN_USER_CMD] == CMD_CONVERT)
			|=> !s_axis_tready)
		else $error("input ready straight after a convert word");

	// NaN results carry zero and no clamp flag
	a_nan_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[OUT_USER_NAN] |->
			(m_axis_tdata == '0) && !m_axis_tuser[OUT_USER_CLMP])
		else $error("NaN result with value or clamp flag");

	// Clamped results are exactly 1.0
	a_clamp_one: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[OUT_USER_CLMP] |-> (m_axis_tdata == ONE))
		else $error("clamped result not equal to 1.0");

	// No result above 1.0
	a_max_one: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			($signed({m_axis_tdata[DATA_W-1], m_axis_tdata}) <= ONE_EXT))
		else $error("result above 1.0");

endmodule

bind knot_table_linear_interpolator_top kli_chk u_kli_chk (.*);
